// ===== rtl/core/swr_meter_bar_scaler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// SWR meter bar scaler assertion macros
// Shared wrappers for concurrent assertions clocked on clk.
// ----------------------------------------------------------------------------
`ifndef SWR_METER_BAR_SCALER_UNIT_ASSERT_SVH
`define SWR_METER_BAR_SCALER_UNIT_ASSERT_SVH

// Checked outside of reset only.
`define SWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SWR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/swrmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// SWR meter bar scaler package
// Widths, stage map, register codes and sideband types of the pipeline.
// ----------------------------------------------------------------------------
package swrmbs_pkg;

  localparam int PW = 16;

  // Square root unit: 48-bit radicand, 24-bit root, two root bits per stage.
  localparam int SQ_XW  = 48;
  localparam int SQ_RW  = 24;
  localparam int SQ_BPS = 2;
  localparam int SQ_ST  = SQ_RW / SQ_BPS;

  // SWR divider: 26-bit dividend, 16-bit divisor and quotient.
  localparam int NUM_W  = 26;
  localparam int DV_BPS = 2;
  localparam int DV_ST  = PW / DV_BPS;

  // Bar dividers.
  localparam int BAR_AW  = 17;
  localparam int BAR_NW  = 25;
  localparam int BAR_QW  = 8;
  localparam int BD_BPS  = 2;
  localparam int BD_ST   = BAR_QW / BD_BPS;
  localparam int NBAR    = 3;

  // Stage map.
  localparam int ST_SQ0  = 2;
  localparam int ST_NUM  = ST_SQ0 + SQ_ST;
  localparam int ST_DV0  = ST_NUM + 1;
  localparam int ST_SWR  = ST_DV0 + DV_ST;
  localparam int ST_PREP = ST_SWR + 1;
  localparam int ST_MUL  = ST_PREP + 1;
  localparam int ST_BD0  = ST_MUL + 1;
  localparam int ST_OUT  = ST_BD0 + BD_ST;
  localparam int NST     = ST_OUT + 1;

  localparam logic [PW-1:0] SWR_ONE = 16'd256;
  localparam logic [PW-1:0] SWR_MAX = 16'hFFFF;

  localparam logic [PW-1:0] RST_SWR_FLOOR      = 16'd256;
  localparam logic [PW-1:0] RST_SWR_MIDPOINT   = 16'd512;
  localparam logic [PW-1:0] RST_POWER_MIDPOINT = 16'd1600;

  typedef enum logic [1:0] {
    REG_SWR_FLOOR      = 2'd0,
    REG_SWR_MIDPOINT   = 2'd1,
    REG_POWER_MIDPOINT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PW-1:0] f;
    logic [PW-1:0] r;
    logic [PW-1:0] rin;
    logic          zr;
    logic          eq;
  } sq_sb_t;

  typedef struct packed {
    logic [PW-1:0] f;
    logic [PW-1:0] rin;
    logic          zr;
    logic          eq;
    logic          sat;
  } dv_sb_t;

  typedef struct packed {
    logic zero;
    logic full;
  } bar_flags_t;

  typedef struct packed {
    logic [BAR_AW-1:0] a;
    logic [BAR_AW-1:0] d;
    bar_flags_t        fl;
  } bar_prep_t;

endpackage

// ===== rtl/core/swrmbs_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// SWR square root pipeline
// Restoring integer square root, two root bits per register stage.
// ----------------------------------------------------------------------------
module swrmbs_sqrt_pipe import swrmbs_pkg::*; #(
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic [SQ_ST-1:0] en,
  input  logic [SQ_XW-1:0] x_in,
  input  logic [SW-1:0]    sb_in,
  output logic [SQ_RW-1:0] root_out,
  output logic [SW-1:0]    sb_out
);

  localparam int RMW = SQ_RW + 2;

  logic [SQ_XW-1:0] x_r    [SQ_ST];
  logic [RMW-1:0]   rem_r  [SQ_ST];
  logic [SQ_RW-1:0] root_r [SQ_ST];
  logic [SW-1:0]    sb_r   [SQ_ST];

  for (genvar k = 0; k < SQ_ST; k++) begin : g_stage
    logic [SQ_XW-1:0] x_src, x_nxt;
    logic [RMW-1:0]   rem_src, rem_nxt;
    logic [SQ_RW-1:0] root_src, root_nxt;
    logic [SW-1:0]    sb_src;

    if (k == 0) begin : g_first
      assign x_src    = x_in;
      assign rem_src  = '0;
      assign root_src = '0;
      assign sb_src   = sb_in;
    end else begin : g_next
      assign x_src    = x_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign root_src = root_r[k-1];
      assign sb_src   = sb_r[k-1];
    end

    always_comb begin
      logic [RMW+1:0] sh;
      logic [RMW+1:0] t;
      x_nxt    = x_src;
      rem_nxt  = rem_src;
      root_nxt = root_src;
      for (int b = 0; b < SQ_BPS; b++) begin
        sh = {rem_nxt, x_nxt[SQ_XW-1 -: 2]};
        t  = {2'b00, root_nxt, 2'b01};
        if (sh >= t) begin
          rem_nxt  = RMW'(sh - t);
          root_nxt = {root_nxt[SQ_RW-2:0], 1'b1};
        end else begin
          rem_nxt  = sh[RMW-1:0];
          root_nxt = {root_nxt[SQ_RW-2:0], 1'b0};
        end
        x_nxt = {x_nxt[SQ_XW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        x_r[k]    <= x_nxt;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sb_r[k]   <= sb_src;
      end
    end
  end

  assign root_out = root_r[SQ_ST-1];
  assign sb_out   = sb_r[SQ_ST-1];

endmodule

// ===== rtl/core/swrmbs_div_pipe.sv =====
// ----------------------------------------------------------------------------
// SWR divider pipeline
// Restoring division with a bounded quotient, BPS quotient bits per stage.
// The dividend must stay below the divisor shifted left by QW.
// ----------------------------------------------------------------------------
module swrmbs_div_pipe #(
  parameter int NW  = 26,
  parameter int DW  = 16,
  parameter int QW  = 16,
  parameter int BPS = 2,
  parameter int SW  = 1
) (
  input  logic               clk,
  input  logic [QW/BPS-1:0]  en,
  input  logic [NW-1:0]      num_in,
  input  logic [DW-1:0]      den_in,
  input  logic [SW-1:0]      sb_in,
  output logic [QW-1:0]      q_out,
  output logic [SW-1:0]      sb_out
);

  localparam int ST = QW / BPS;
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r [ST];
  logic [DW-1:0] den_r [ST];
  logic [QW-1:0] q_r   [ST];
  logic [SW-1:0] sb_r  [ST];

  for (genvar k = 0; k < ST; k++) begin : g_stage
    logic [NW-1:0] rem_src, rem_nxt;
    logic [DW-1:0] den_src;
    logic [QW-1:0] q_src, q_nxt;
    logic [SW-1:0] sb_src;

    if (k == 0) begin : g_first
      assign rem_src = num_in;
      assign den_src = den_in;
      assign q_src   = '0;
      assign sb_src  = sb_in;
    end else begin : g_next
      assign rem_src = rem_r[k-1];
      assign den_src = den_r[k-1];
      assign q_src   = q_r[k-1];
      assign sb_src  = sb_r[k-1];
    end

    always_comb begin
      logic [CW-1:0] r;
      logic [CW-1:0] dsh;
      r     = CW'(rem_src);
      q_nxt = q_src;
      for (int b = 0; b < BPS; b++) begin
        dsh = CW'(den_src) << (QW - 1 - k * BPS - b);
        if (r >= dsh) begin
          r     = r - dsh;
          q_nxt = {q_nxt[QW-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[QW-2:0], 1'b0};
        end
      end
      rem_nxt = NW'(r);
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_src;
        q_r[k]   <= q_nxt;
        sb_r[k]  <= sb_src;
      end
    end
  end

  assign q_out  = q_r[ST-1];
  assign sb_out = sb_r[ST-1];

endmodule

// ===== rtl/core/swr_meter_bar_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// SWR meter bar scaler
// Standing wave ratio from forward and reflected power, plus three
// log-scale bar lengths, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Channel  Direction  Beat contents
// in_      slave      tdata: fwd_power [15:0], rev_power [31:16]
// out_     master     tdata: swr_value, swr/fwd/rev bar lengths; tuser: infinite
// cfg_     slave      cfg_index selects floor, SWR midpoint or power midpoint
//
// One beat enters per clock cycle while the output side is not held; the
// pipeline is built from the 12-stage square root, the 8-stage SWR divider
// and the 4-stage bar dividers.
// Reset is synchronous and active low; it empties the pipeline and loads the
// default register values (floor 1.0, SWR midpoint 2.0, power midpoint 100 W).
// Each stage holds its beat only while the stage after it is full and held,
// so bubbles close up under backpressure and no beat is lost or repeated.
// ----------------------------------------------------------------------------
`include "swr_meter_bar_scaler_unit_assert.svh"

module swr_meter_bar_scaler_unit import swrmbs_pkg::*; #(
  parameter int BAR_WIDTH = 108
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // fwd_power [15:0], rev_power [31:16]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // swr_value [15:0], swr_bar_len [22:16],
                                  // fwd_bar_len [29:23], rev_bar_len [36:30]
  output logic [0:0]  out_tuser,  // swr_infinite [0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Bar lengths are reported in 7 bits, so a full bar wraps like the length.
  localparam logic [7:0] BAR_W8       = 8'(BAR_WIDTH);
  localparam logic [6:0] BAR_LEN_FULL = 7'(BAR_WIDTH);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are registered; the port never stalls.
  // --------------------------------------------------------------------------
  logic [PW-1:0] swr_floor_r, swr_mid_r, pwr_mid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swr_floor_r <= RST_SWR_FLOOR;
      swr_mid_r   <= RST_SWR_MIDPOINT;
      pwr_mid_r   <= RST_POWER_MIDPOINT;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SWR_FLOOR:      swr_floor_r <= cfg_data;
        REG_SWR_MIDPOINT:   swr_mid_r   <= cfg_data;
        REG_POWER_MIDPOINT: pwr_mid_r   <= cfg_data;
        default: ;  // unused index, write is dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage valid bits and per-stage enables. A stage loads when it is empty
  // or when the stage after it loads too.
  // --------------------------------------------------------------------------
  logic [NST-1:0] v_r, v_nxt, en;

  assign en[NST-1] = !v_r[NST-1] || out_tready;
  for (genvar gi = 0; gi < NST - 1; gi++) begin : g_en
    assign en[gi] = !v_r[gi] || en[gi+1];
  end

  assign v_nxt = (en & {v_r[NST-2:0], in_tvalid}) | (~en & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = en[0];

  // --------------------------------------------------------------------------
  // Stage 0: capture the beat.
  // --------------------------------------------------------------------------
  logic [PW-1:0] s0_f_r, s0_rin_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_f_r   <= in_tdata[15:0];
      s0_rin_r <= in_tdata[31:16];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: clamp reflected to forward, classify, form f * r.
  // --------------------------------------------------------------------------
  logic [PW-1:0]   s1_r;
  sq_sb_t          s1_sb_r;
  logic [2*PW-1:0] s1_p_r;

  assign s1_r = (s0_rin_r > s0_f_r) ? s0_f_r : s0_rin_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_sb_r.f   <= s0_f_r;
      s1_sb_r.r   <= s1_r;
      s1_sb_r.rin <= s0_rin_r;
      s1_sb_r.zr  <= (s1_r == '0);
      s1_sb_r.eq  <= (s1_r == s0_f_r) && (s1_r != '0);
      s1_p_r      <= s0_f_r * s1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Square root of f * r * 65536, i.e. 256 * sqrt(f r) rounded down.
  // --------------------------------------------------------------------------
  logic [SQ_RW-1:0] sq_root;
  sq_sb_t           sq_sb;

  swrmbs_sqrt_pipe #(
    .SW ($bits(sq_sb_t))
  ) u_sqrt (
    .clk      (clk),
    .en       (en[ST_SQ0 +: SQ_ST]),
    .x_in     ({s1_p_r, 16'h0000}),
    .sb_in    (s1_sb_r),
    .root_out (sq_root),
    .sb_out   (sq_sb)
  );

  // --------------------------------------------------------------------------
  // Dividend 256 (f + r) + 2 s and divisor f - r. A quotient that would need
  // more than 16 bits is flagged here and saturates after the divider.
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0] num_c;
  logic [PW-1:0]    den_c;
  logic [NUM_W-1:0] sn_num_r;
  logic [PW-1:0]    sn_den_r;
  dv_sb_t           sn_sb_r;

  assign num_c = NUM_W'({{1'b0, sq_sb.f} + {1'b0, sq_sb.r}, 8'h00})
               + NUM_W'({sq_root, 1'b0});
  assign den_c = sq_sb.f - sq_sb.r;

  always_ff @(posedge clk) begin
    if (en[ST_NUM]) begin
      sn_num_r    <= num_c;
      sn_den_r    <= den_c;
      sn_sb_r.f   <= sq_sb.f;
      sn_sb_r.rin <= sq_sb.rin;
      sn_sb_r.zr  <= sq_sb.zr;
      sn_sb_r.eq  <= sq_sb.eq;
      sn_sb_r.sat <= PW'(num_c[NUM_W-1:16]) >= den_c;
    end
  end

  logic [PW-1:0] dv_q;
  dv_sb_t        dv_sb;

  swrmbs_div_pipe #(
    .NW  (NUM_W),
    .DW  (PW),
    .QW  (PW),
    .BPS (DV_BPS),
    .SW  ($bits(dv_sb_t))
  ) u_swr_div (
    .clk    (clk),
    .en     (en[ST_DV0 +: DV_ST]),
    .num_in (sn_num_r),
    .den_in (sn_den_r),
    .sb_in  (sn_sb_r),
    .q_out  (dv_q),
    .sb_out (dv_sb)
  );

  // --------------------------------------------------------------------------
  // Final SWR value. No reflected power reads as 1.0, equal powers as an
  // unbounded ratio, and an oversized quotient saturates.
  // --------------------------------------------------------------------------
  logic [PW-1:0] sw_swr_r, sw_f_r, sw_rin_r;
  logic          sw_inf_r;

  always_ff @(posedge clk) begin
    if (en[ST_SWR]) begin
      if (dv_sb.zr) begin
        sw_swr_r <= SWR_ONE;
      end else if (dv_sb.eq || dv_sb.sat) begin
        sw_swr_r <= SWR_MAX;
      end else begin
        sw_swr_r <= dv_q;
      end
      sw_inf_r <= dv_sb.eq;
      sw_f_r   <= dv_sb.f;
      sw_rin_r <= dv_sb.rin;
    end
  end

  // --------------------------------------------------------------------------
  // Bar setup. Below the midpoint the bar is v / (2 m) of full length, at or
  // above it (2 v - m) / (2 v). Zero and full bars are decided here and
  // override the divider result at the output.
  // --------------------------------------------------------------------------
  function automatic bar_prep_t bar_prep(input logic signed [17:0] v,
                                         input logic signed [17:0] m,
                                         input logic               inf);
    bar_prep_t        p;
    logic signed [17:0] v2;
    logic signed [17:0] m2;
    v2        = v <<< 1;
    m2        = m <<< 1;
    p.fl.zero = (v <= 18'sd0) && !inf;
    p.fl.full = inf || (m <= 18'sd0);
    if (v < m) begin
      p.a = v[BAR_AW-1:0];
      p.d = m2[BAR_AW-1:0];
    end else begin
      p.a = BAR_AW'(v2 - m);
      p.d = v2[BAR_AW-1:0];
    end
    return p;
  endfunction

  bar_prep_t     bp_r [NBAR];
  logic [PW-1:0] bp_swr_r;
  logic          bp_inf_r;

  always_ff @(posedge clk) begin
    if (en[ST_PREP]) begin
      bp_r[0]  <= bar_prep($signed({2'b00, sw_swr_r}) - $signed({2'b00, swr_floor_r}),
                           $signed({2'b00, swr_mid_r}) - $signed({2'b00, swr_floor_r}),
                           sw_inf_r);
      bp_r[1]  <= bar_prep($signed({2'b00, sw_f_r}), $signed({2'b00, pwr_mid_r}), 1'b0);
      bp_r[2]  <= bar_prep($signed({2'b00, sw_rin_r}), $signed({2'b00, pwr_mid_r}), 1'b0);
      bp_swr_r <= sw_swr_r;
      bp_inf_r <= sw_inf_r;
    end
  end

  // Scale the numerator by the bar width.
  logic [BAR_NW-1:0] mu_n_r  [NBAR];
  logic [BAR_AW-1:0] mu_d_r  [NBAR];
  bar_flags_t        mu_fl_r [NBAR];
  logic [PW-1:0]     mu_swr_r;
  logic              mu_inf_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      for (int i = 0; i < NBAR; i++) begin
        mu_n_r[i]  <= BAR_NW'(BAR_W8) * BAR_NW'(bp_r[i].a);
        mu_d_r[i]  <= bp_r[i].d;
        mu_fl_r[i] <= bp_r[i].fl;
      end
      mu_swr_r <= bp_swr_r;
      mu_inf_r <= bp_inf_r;
    end
  end

  // --------------------------------------------------------------------------
  // Three bar dividers side by side; the SWR value rides a matching delay.
  // --------------------------------------------------------------------------
  logic [BAR_QW-1:0] bd_q  [NBAR];
  bar_flags_t        bd_fl [NBAR];

  for (genvar gb = 0; gb < NBAR; gb++) begin : g_bar
    swrmbs_div_pipe #(
      .NW  (BAR_NW),
      .DW  (BAR_AW),
      .QW  (BAR_QW),
      .BPS (BD_BPS),
      .SW  ($bits(bar_flags_t))
    ) u_bar_div (
      .clk    (clk),
      .en     (en[ST_BD0 +: BD_ST]),
      .num_in (mu_n_r[gb]),
      .den_in (mu_d_r[gb]),
      .sb_in  (mu_fl_r[gb]),
      .q_out  (bd_q[gb]),
      .sb_out (bd_fl[gb])
    );
  end

  logic [PW-1:0] dl_swr_r [BD_ST];
  logic          dl_inf_r [BD_ST];

  for (genvar gd = 0; gd < BD_ST; gd++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[ST_BD0 + gd]) begin
        dl_swr_r[gd] <= (gd == 0) ? mu_swr_r : dl_swr_r[(gd == 0) ? 0 : gd - 1];
        dl_inf_r[gd] <= (gd == 0) ? mu_inf_r : dl_inf_r[(gd == 0) ? 0 : gd - 1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic [6:0]    ob_len_r [NBAR];
  logic [PW-1:0] ob_swr_r;
  logic          ob_inf_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      for (int i = 0; i < NBAR; i++) begin
        if (bd_fl[i].zero) begin
          ob_len_r[i] <= '0;
        end else if (bd_fl[i].full) begin
          ob_len_r[i] <= BAR_LEN_FULL;
        end else begin
          ob_len_r[i] <= bd_q[i][6:0];
        end
      end
      ob_swr_r <= dl_swr_r[BD_ST-1];
      ob_inf_r <= dl_inf_r[BD_ST-1];
    end
  end

  assign out_tvalid   = v_r[NST-1];
  assign out_tdata    = {3'b000, ob_len_r[2], ob_len_r[1], ob_len_r[0], ob_swr_r};
  assign out_tuser[0] = ob_inf_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An unbounded ratio always shows the saturated value and a full SWR bar.
  `SWR_ASSERT(a_inf_full, out_tvalid && out_tuser[0] |-> out_tdata[15:0] == SWR_MAX && out_tdata[22:16] == BAR_LEN_FULL, "infinite SWR without saturated value and full bar")
  // The ratio can never fall below 1.0.
  `SWR_ASSERT(a_swr_min, out_tvalid |-> out_tdata[15:0] >= SWR_ONE, "SWR below 1.0")
  // Input backpressure only when every stage is full and the output is held.
  `SWR_ASSERT(a_stall_full, !in_tready |-> out_tvalid && !out_tready && v_r == '1, "input stalled with room in pipeline")
  // Reset empties the pipeline.
  `SWR_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid && in_tready, "pipeline not empty after reset")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// SWR meter bar scaler testbench
// Drives forward/reflected power beats into the scaler, predicts SWR, the
// unbounded flag and the three bar lengths for every accepted beat, and
// compares them in order with the result beats. Register settings change
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
import swrmbs_pkg::*;

typedef struct packed {
  logic [15:0] swr_value;
  logic        swr_infinite;
  logic [6:0]  swr_bar_len;
  logic [6:0]  fwd_bar_len;
  logic [6:0]  rev_bar_len;
} meter_reading_t;

class meter_scoreboard;
  logic [15:0]    swr_floor_q, swr_mid_q, pwr_mid_q;
  meter_reading_t pending[$];
  int             n_errors;
  int             n_checked;
  int             n_infinite;

  function new();
    swr_floor_q = RST_SWR_FLOOR;
    swr_mid_q   = RST_SWR_MIDPOINT;
    pwr_mid_q   = RST_POWER_MIDPOINT;
    n_errors    = 0;
    n_checked   = 0;
    n_infinite  = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [15:0] val);
    case (idx)
      REG_SWR_FLOOR:      swr_floor_q = val;
      REG_SWR_MIDPOINT:   swr_mid_q   = val;
      REG_POWER_MIDPOINT: pwr_mid_q   = val;
      default: ;
    endcase
  endfunction

  // Bit-by-bit integer square root, floor.
  function longint unsigned isqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Log-scale bar: v/(2m) below the midpoint, 1 - m/(2v) at or above it.
  function logic [6:0] bar_pixels(longint v, longint m);
    longint unsigned len;
    if (v <= 0) return 7'd0;
    if (m <= 0) return 7'(108);
    if (v < m) len = (108 * v) / (2 * m);
    else       len = (108 * (2 * v - m)) / (2 * v);
    return len[6:0];
  endfunction

  function void note_sample(logic [15:0] fwd, logic [15:0] rev);
    meter_reading_t  e;
    longint unsigned f, r, s, q;
    f = 64'(fwd);
    r = 64'((rev > fwd) ? fwd : rev);
    e.swr_infinite = 1'b0;
    if (r == 0) begin
      q = 256;
    end else if (r == f) begin
      q = 16'hFFFF;
      e.swr_infinite = 1'b1;
    end else begin
      s = isqrt((f * r) << 16);
      q = (256 * (f + r) + 2 * s) / (f - r);
      if (q > 16'hFFFF) q = 16'hFFFF;
    end
    e.swr_value = q[15:0];
    if (e.swr_infinite) e.swr_bar_len = 7'(108);
    else e.swr_bar_len = bar_pixels(longint'(q) - longint'(swr_floor_q),
                                    longint'(swr_mid_q) - longint'(swr_floor_q));
    e.fwd_bar_len = bar_pixels(longint'(f), longint'(pwr_mid_q));
    e.rev_bar_len = bar_pixels(longint'(rev), longint'(pwr_mid_q));
    pending.push_back(e);
  endfunction

  function void check_reading(meter_reading_t got);
    meter_reading_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result beat %h", $time, got);
      n_errors++;
      return;
    end
    e = pending.pop_front();
    n_checked++;
    if (got.swr_infinite) n_infinite++;
    if (got.swr_value !== e.swr_value) begin
      $display("%0t: swr_value expected %0d actual %0d", $time, e.swr_value, got.swr_value);
      n_errors++;
    end
    if (got.swr_infinite !== e.swr_infinite) begin
      $display("%0t: swr_infinite expected %0d actual %0d", $time,
               e.swr_infinite, got.swr_infinite);
      n_errors++;
    end
    if (got.swr_bar_len !== e.swr_bar_len) begin
      $display("%0t: swr_bar_len expected %0d actual %0d", $time,
               e.swr_bar_len, got.swr_bar_len);
      n_errors++;
    end
    if (got.fwd_bar_len !== e.fwd_bar_len) begin
      $display("%0t: fwd_bar_len expected %0d actual %0d", $time,
               e.fwd_bar_len, got.fwd_bar_len);
      n_errors++;
    end
    if (got.rev_bar_len !== e.rev_bar_len) begin
      $display("%0t: rev_bar_len expected %0d actual %0d", $time,
               e.rev_bar_len, got.rev_bar_len);
      n_errors++;
    end
  endfunction
endclass

module testbench;
  localparam int LATENCY     = 31;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  meter_scoreboard meter_sb;
  int              cycle_count;
  int              n_sent;
  bit              calm_mode;     // no idling on either side near the end

  swr_meter_bar_scaler_unit #(.BAR_WIDTH(108)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Watchdog: the slowest correct run is far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: every handshake is checked; ready drops in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      meter_reading_t got;
      got.swr_value    = out_tdata[15:0];
      got.swr_bar_len  = out_tdata[22:16];
      got.fwd_bar_len  = out_tdata[29:23];
      got.rev_bar_len  = out_tdata[36:30];
      got.swr_infinite = out_tuser[0];
      meter_sb.check_reading(got);
    end
  end

  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || calm_mode) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One power sample beat; an idle burst may come before it.
  task automatic send_sample(logic [15:0] fwd, logic [15:0] rev);
    if (!calm_mode && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rev, fwd};
    do @(posedge clk); while (!in_tready);
    meter_sb.note_sample(fwd, rev);
    n_sent++;
  endtask

  // Lets the pipeline empty before a register write or at the end.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (meter_sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    meter_sb.write_reg(idx, val);
  endtask

  // Mostly reflected below forward with useful ratios; also equal, zero, above.
  task automatic send_random_sample();
    logic [15:0] f, r;
    case ($urandom_range(0, 9))
      0:       begin f = 16'($urandom); r = f; end
      1:       begin f = 16'($urandom); r = 16'd0; end
      2:       begin f = 16'($urandom); r = 16'($urandom); end
      3:       begin
        f = 16'($urandom_range(0, 4000));
        r = 16'($urandom_range(0, 4000));
      end
      default: begin
        f = 16'($urandom_range(1, 65535));
        r = 16'($urandom_range(0, f));
        if ($urandom_range(0, 1)) r = r >> $urandom_range(0, 6);
      end
    endcase
    send_sample(f, r);
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) send_random_sample();
  endtask

  initial begin
    meter_sb    = new();
    cycle_count = 0;
    n_sent      = 0;
    calm_mode   = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_SWR_FLOOR;
    cfg_data    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, zero reflected, equal powers, clamping.
    send_sample(16'd0, 16'd0);           // nothing at all: SWR 1.0
    send_sample(16'hFFFF, 16'd0);
    send_sample(16'd0, 16'hFFFF);        // reflected clamped to zero forward
    send_sample(16'hFFFF, 16'hFFFF);     // equal: unbounded
    send_sample(16'd1, 16'd1);
    send_sample(16'd100, 16'd400);       // reflected above forward
    send_sample(16'hFFFF, 16'hFFFE);     // saturating ratio
    send_sample(16'hFFFF, 16'd1);
    send_sample(16'd1600, 16'd1600);
    send_sample(16'd1600, 16'd178);      // SWR near 2.0, midpoint of power bar
    send_sample(16'd1599, 16'd1601);
    send_sample(16'd3200, 16'd800);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
    send_sample(16'd2, 16'd1);
    drain_results();

    // Midpoint at floor (full bar for anything above), unit power midpoint.
    write_reg(REG_SWR_FLOOR, 16'd512);
    write_reg(REG_SWR_MIDPOINT, 16'd512);
    write_reg(REG_POWER_MIDPOINT, 16'd1);
    send_sample(16'd1000, 16'd0);        // SWR below floor: empty bar
    send_sample(16'd1000, 16'd500);
    send_sample(16'd1, 16'd0);
    random_phase(60);
    drain_results();

    // Upper extremes; midpoint below floor.
    write_reg(REG_SWR_FLOOR, 16'hFFFF);
    write_reg(REG_SWR_MIDPOINT, 16'd257);
    write_reg(REG_POWER_MIDPOINT, 16'hFFFF);
    random_phase(60);
    drain_results();

    write_reg(REG_SWR_FLOOR, 16'd256);
    write_reg(REG_SWR_MIDPOINT, 16'hFFFF);
    write_reg(REG_POWER_MIDPOINT, 16'd16);
    random_phase(80);
    drain_results();

    // Random mid-range settings; the last phase runs with no idling.
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_SWR_FLOOR, 16'($urandom_range(256, 1024)));
      write_reg(REG_SWR_MIDPOINT, 16'($urandom_range(257, 4096)));
      write_reg(REG_POWER_MIDPOINT, 16'($urandom_range(1, 65535)));
      if (p == 2) calm_mode = 1'b1;
      random_phase(60);
      drain_results();
    end

    $display("Sent %0d power samples over seven register settings; %0d results checked,",
             n_sent, meter_sb.n_checked);
    $display("%0d of them with an unbounded ratio.", meter_sb.n_infinite);
    if (meter_sb.n_errors == 0 && meter_sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
